/* rtl/csb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_pkg - shared definitions for the caesar shift buffer device
// widths, address map, alphabet constants and the controller state type
// ----------------------------------------------------------------------------
package csb_pkg;

	// word fields
	localparam int ADDR_W = 12;
	localparam int SIZE_W = 4;
	localparam int DATA_W = 32;

	// access codes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// address map
	localparam logic [ADDR_W-1:0] SEED_OFFSET = 12'h000;
	localparam logic [ADDR_W-1:0] BUF_BASE    = 12'h004;
	localparam logic [SIZE_W-1:0] BUF_SIZE    = 4'd1;

	// text buffer
	localparam int BUF_BYTES = 256;
	localparam int BUF_AW    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

	// alphabet
	localparam int          ALPHA_LEN = 26;
	localparam int          REM_W     = $clog2(ALPHA_LEN);
	localparam logic [7:0]  CH_UP_A   = 8'h41;
	localparam logic [7:0]  CH_UP_Z   = 8'h5a;
	localparam logic [7:0]  CH_LO_A   = 8'h61;
	localparam logic [7:0]  CH_LO_Z   = 8'h7a;

	// when letter + seed wraps past 2^32, the sum drops by 2^32, i.e. this much mod 26
	localparam longint unsigned SEED_SPAN = 64'h1_0000_0000;
	localparam int WRAP_ADJ = ALPHA_LEN - int'(SEED_SPAN % ALPHA_LEN);

	// seed residue: bytes weighted by 2^(8k) mod 26, then a reciprocal reduction
	localparam int RES_B1   = (1 << 8) % ALPHA_LEN;
	localparam int RES_B2   = (1 << 16) % ALPHA_LEN;
	localparam int RES_B3   = (1 << 24) % ALPHA_LEN;
	localparam int FOLD_W   = 14;
	localparam int RECIP_SH = 19;
	localparam int RECIP_W  = 15;
	localparam int RECIP_M  = ((1 << RECIP_SH) + ALPHA_LEN - 1) / ALPHA_LEN;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_MOD  = 3'b100
	} csb_state_t;

endpackage

/* rtl/csb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_req_if / csb_rsp_if - valid/ready channels of the device
// request word carries the bus access, response word carries read data
// ----------------------------------------------------------------------------
interface csb_req_if
	import csb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              command;
	logic [ADDR_W-1:0] address;
	logic [SIZE_W-1:0] access_size;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, command, address, access_size, write_data, input ready);
	modport sink   (input valid, command, address, access_size, write_data, output ready);
endinterface

interface csb_rsp_if
	import csb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink   (input valid, read_data, output ready);
endinterface

/* rtl/caesar_shift_buffer_device.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caesar_shift_buffer_device - register-mapped caesar shift byte buffer
// offset 0 holds the shift seed; one-byte writes at offset 4 and up store a
// letter-shifted byte into the text buffer, one-byte reads return it
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  --------+-----+---------------+------------------------------------------
//  req     | in  | valid / ready | command, address, access_size, write_data
//  rsp     | out | valid / ready | read_data (one word per read access)
//
//  buffer and unmapped accesses go through accept, then execute against
//  the synchronous buffer ram (read issued at accept, data back next cycle)
//  a seed write adds a third step: the seed is folded to a short residue in the
//  execute cycle and reduced mod 26 by a reciprocal multiply in the next
//  reset clears seed and per-entry valid flags at once; no clearing pass
//  a stalled rsp holds the executing read; req is still taken while a
//  finished response waits in the output register
// ----------------------------------------------------------------------------
module caesar_shift_buffer_device
	import csb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	csb_req_if.sink   req,
	csb_rsp_if.source rsp
);

	csb_state_t state_q;

	// accepted word
	logic              cmd_s1;
	logic              seed_hit_s1;
	logic              buf_hit_s1;
	logic [BUF_AW-1:0] pos_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic [7:0]        rdata_s1;

	// seed and its remainder
	logic [DATA_W-1:0] seed_q;
	logic [REM_W-1:0]  rem_q;
	logic [FOLD_W-1:0] fold_q;

	// text buffer ram and valid flags
	logic [7:0]           buf_mem [BUF_BYTES];
	logic [BUF_BYTES-1:0] vld_q;

	// output register
	logic              rsp_valid_q;
	logic [DATA_W-1:0] rsp_data_q;

	logic                      accept;
	logic [ADDR_W-1:0]         pos_full;
	logic                      in_hit;
	logic                      rsp_free;
	logic                      exec_done;
	logic                      mem_we;
	logic [7:0]                shifted;
	logic [DATA_W-1:0]         read_word;
	logic [FOLD_W-1:0]         fold_next;
	logic [FOLD_W+RECIP_W-1:0] fold_prod;
	logic [FOLD_W-1:0]         fold_quo;
	logic [REM_W-1:0]          fold_rem;

	// letter shift using the stored remainder; a wrap of letter + seed past
	// 2^32 is folded back in as a constant offset
	function automatic logic [7:0] shift_letter(
		input logic [7:0]        ch,
		input logic [DATA_W-1:0] seed,
		input logic [REM_W-1:0]  rem
	);
		logic [7:0]      base;
		logic            is_letter;
		logic [REM_W-1:0] x;
		logic [DATA_W:0] sum;
		logic [REM_W:0]  t;
		begin
			base      = CH_UP_A;
			is_letter = 1'b1;
			if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
				base = CH_UP_A;
			end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
				base = CH_LO_A;
			end else begin
				is_letter = 1'b0;
			end
			x   = REM_W'(ch - base);
			sum = {1'b0, seed} + (DATA_W+1)'(x);
			t   = (REM_W+1)'(x) + (REM_W+1)'(rem)
				+ (sum[DATA_W] ? (REM_W+1)'(WRAP_ADJ) : '0);
			if (t >= (REM_W+1)'(2 * ALPHA_LEN)) begin
				t = t - (REM_W+1)'(2 * ALPHA_LEN);
			end else if (t >= (REM_W+1)'(ALPHA_LEN)) begin
				t = t - (REM_W+1)'(ALPHA_LEN);
			end
			shift_letter = is_letter ? (base + 8'(t)) : ch;
		end
	endfunction

	// decode at accept
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign pos_full  = req.address - BUF_BASE;
	assign in_hit    = (req.address >= BUF_BASE) && (req.access_size == BUF_SIZE)
		&& (pos_full < ADDR_W'(BUF_BYTES));

	// execute stage
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign exec_done = (state_q == ST_EXEC) && ((cmd_s1 == CMD_WRITE) || rsp_free);
	assign mem_we    = (state_q == ST_EXEC) && (cmd_s1 == CMD_WRITE) && !seed_hit_s1
		&& buf_hit_s1;
	assign shifted   = shift_letter(wdata_s1[7:0], seed_q, rem_q);

	always_comb begin
		read_word = '0;
		if (seed_hit_s1) begin
			read_word = seed_q;
		end else if (buf_hit_s1 && vld_q[pos_s1]) begin
			read_word = DATA_W'(rdata_s1);
		end
	end

	// seed residue: each byte weighted by its power of 256 mod 26
	assign fold_next = FOLD_W'(wdata_s1[7:0])
		+ FOLD_W'(wdata_s1[15:8]) * FOLD_W'(RES_B1)
		+ FOLD_W'(wdata_s1[23:16]) * FOLD_W'(RES_B2)
		+ FOLD_W'(wdata_s1[31:24]) * FOLD_W'(RES_B3);

	// residue mod 26: quotient by reciprocal multiply, exact over the fold range
	assign fold_prod = (FOLD_W+RECIP_W)'(fold_q) * (FOLD_W+RECIP_W)'(RECIP_M);
	assign fold_quo  = FOLD_W'(fold_prod >> RECIP_SH);
	assign fold_rem  = REM_W'(fold_q - fold_quo * FOLD_W'(ALPHA_LEN));

	// buffer ram: read issued at accept, written in the execute cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			buf_mem[pos_s1] <= shifted;
		end
		if (accept && in_hit) begin
			rdata_s1 <= buf_mem[pos_full[BUF_AW-1:0]];
		end
	end

	// accepted word and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= req.command;
			seed_hit_s1 <= (req.address == SEED_OFFSET);
			buf_hit_s1  <= in_hit;
			pos_s1      <= pos_full[BUF_AW-1:0];
			wdata_s1    <= req.write_data;
		end
		if (exec_done && (cmd_s1 == CMD_READ)) begin
			rsp_data_q <= read_word;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= '0;
			rem_q       <= '0;
			fold_q      <= '0;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (mem_we) begin
				vld_q[pos_s1] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_done) begin
						if (cmd_s1 == CMD_READ) begin
							rsp_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else if (seed_hit_s1) begin
							// new seed: fold it now, reduce it next cycle
							seed_q  <= wdata_s1;
							fold_q  <= fold_next;
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_MOD: begin
					rem_q   <= fold_rem;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the caesar shift buffer device
// directed table over reset state, seed extremes, letter edges and ignored
// accesses, then a random mix under three idling profiles, every response
// word checked against a typed value or a behavioural copy of the seed and text buffer
// ----------------------------------------------------------------------------
module tb_top;
	import csb_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	localparam int PHASE_WORDS  = 433;
	localparam int BURST_WORDS  = 48;
	localparam int LONG_STALL   = 400;
	localparam int MAX_GAP      = 30;
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_MAX = 3000;

	// directed rows either carry the expected read word or defer to the model
	localparam bit TYPED = 1'b1;
	localparam bit MODEL = 1'b0;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		logic [DATA_W-1:0] data;
		bit                typed;
		logic [DATA_W-1:0] exp_rd;
	} dir_row_t;

	localparam int DIR_ROWS = 26;
	localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
		// reset state: seed, first and stray buffer entries all read zero
		'{CMD_READ,  SEED_OFFSET, 4'd4,  32'h0,              TYPED, 32'h0},
		'{CMD_READ,  12'd4,       4'd1,  32'h0,              TYPED, 32'h0},
		'{CMD_READ,  12'd4095,    4'd1,  32'h0,              TYPED, 32'h0},
		// largest seed; the letter written is A, so the letter sum stays just below 2^32
		'{CMD_WRITE, SEED_OFFSET, 4'd4,  32'hffff_ffff,      MODEL, 32'h0},
		'{CMD_READ,  SEED_OFFSET, 4'd8,  32'h0,              TYPED, 32'hffff_ffff},
		'{CMD_WRITE, 12'd4,       4'd1,  {24'hffffff, CH_UP_A}, MODEL, 32'h0},
		'{CMD_READ,  12'd4,       4'd1,  32'h0,              MODEL, 32'h0},
		// last buffer entry, then one past it
		'{CMD_WRITE, 12'd259,     4'd1,  {24'h0, CH_LO_Z},   MODEL, 32'h0},
		'{CMD_READ,  12'd259,     4'd1,  32'h0,              MODEL, 32'h0},
		'{CMD_WRITE, 12'd260,     4'd1,  32'h0000_0051,      MODEL, 32'h0},
		'{CMD_READ,  12'd260,     4'd1,  32'h0,              TYPED, 32'h0},
		// offsets between seed and buffer
		'{CMD_WRITE, 12'd2,       4'd1,  32'ha5a5_a5a5,      MODEL, 32'h0},
		'{CMD_READ,  12'd2,       4'd1,  32'h0,              TYPED, 32'h0},
		// buffer access with the wrong width
		'{CMD_WRITE, 12'd5,       4'd2,  32'h0000_0062,      MODEL, 32'h0},
		'{CMD_READ,  12'd5,       4'd1,  32'h0,              TYPED, 32'h0},
		// bytes just outside the two letter ranges pass through
		'{CMD_WRITE, 12'd5,       4'd1,  32'h0000_005b,      MODEL, 32'h0},
		'{CMD_READ,  12'd5,       4'd1,  32'h0,              TYPED, 32'h0000_005b},
		'{CMD_WRITE, 12'd6,       4'd1,  32'h0000_007b,      MODEL, 32'h0},
		'{CMD_READ,  12'd6,       4'd1,  32'h0,              TYPED, 32'h0000_007b},
		// zero seed written with a one-byte access, letter stays put
		'{CMD_WRITE, SEED_OFFSET, 4'd1,  32'h0,              MODEL, 32'h0},
		'{CMD_WRITE, 12'd8,       4'd1,  {24'hffffff, CH_UP_Z}, MODEL, 32'h0},
		'{CMD_READ,  12'd8,       4'd1,  32'h0,              TYPED, {24'h0, CH_UP_Z}},
		// seed of 25 through the widest size field
		'{CMD_WRITE, SEED_OFFSET, 4'd15, 32'd25,             MODEL, 32'h0},
		'{CMD_WRITE, 12'd9,       4'd1,  {24'h0, CH_LO_A},   MODEL, 32'h0},
		'{CMD_READ,  12'd9,       4'd1,  32'h0,              MODEL, 32'h0},
		'{CMD_READ,  SEED_OFFSET, 4'd0,  32'h0,              TYPED, 32'd25}
	};

	logic clk;
	logic arst_n;

	csb_req_if req_ch ();
	csb_rsp_if rsp_ch ();

	caesar_shift_buffer_device dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// behavioural copy of the device state
	logic [DATA_W-1:0] model_seed;
	logic [7:0]        model_text [BUF_BYTES];
	logic [DATA_W-1:0] pending_reads [$];

	int fail_cnt;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_req;
	int stall_seen;
	int stall_left;

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// letters rotate within their own case, everything else is untouched
	function automatic logic [7:0] shift_byte(logic [7:0] ch, logic [DATA_W-1:0] seed);
		logic [7:0]        base;
		logic [DATA_W-1:0] sum;
		if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
			base = CH_UP_A;
		end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
			base = CH_LO_A;
		end else begin
			return ch;
		end
		sum = DATA_W'(ch - base) + seed;
		return base + 8'(sum % ALPHA_LEN);
	endfunction

	// applies one accepted word to the model, hands back the read word if any
	task automatic model_access(input logic cmd, input logic [ADDR_W-1:0] addr,
			input logic [SIZE_W-1:0] size, input logic [DATA_W-1:0] data,
			output bit has_read, output logic [DATA_W-1:0] rd);
		bit                buf_hit;
		logic [ADDR_W-1:0] pos;
		pos     = addr - BUF_BASE;
		buf_hit = (addr >= BUF_BASE) && (size == BUF_SIZE) && (pos < BUF_BYTES);
		has_read = (cmd == CMD_READ);
		rd = '0;
		if (cmd == CMD_WRITE) begin
			if (addr == SEED_OFFSET) begin
				model_seed = data;
			end else if (buf_hit) begin
				model_text[pos[BUF_AW-1:0]] = shift_byte(data[7:0], model_seed);
			end
		end else if (addr == SEED_OFFSET) begin
			rd = model_seed;
		end else if (buf_hit) begin
			rd = {24'h0, model_text[pos[BUF_AW-1:0]]};
		end
	endtask

	// offers one word, waits for the handshake, then records what it should return
	task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr,
			input logic [SIZE_W-1:0] size, input logic [DATA_W-1:0] data,
			input bit typed, input logic [DATA_W-1:0] typed_rd);
		int                gap;
		bit                has_read;
		logic [DATA_W-1:0] rd;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.command     <= cmd;
		req_ch.address     <= addr;
		req_ch.access_size <= size;
		req_ch.write_data  <= data;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		model_access(cmd, addr, size, data, has_read, rd);
		if (has_read)
			pending_reads.push_back(typed ? typed_rd : rd);
	endtask

	// random word: mostly buffer traffic on letters, some seed updates, some strays
	task automatic send_random_word();
		int                pick;
		int                pos;
		logic [7:0]        ch;
		logic [DATA_W-1:0] data;
		pick = $urandom_range(0, 99);
		pos  = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 255);
		data = $urandom;
		case ($urandom_range(0, 3))
			0: ch = CH_UP_A + 8'($urandom_range(0, ALPHA_LEN - 1));
			1: ch = CH_LO_A + 8'($urandom_range(0, ALPHA_LEN - 1));
			2: ch = 8'($urandom);
			default: begin
				case ($urandom_range(0, 7))
					0: ch = CH_UP_A - 8'd1;
					1: ch = CH_UP_A;
					2: ch = CH_UP_Z;
					3: ch = CH_UP_Z + 8'd1;
					4: ch = CH_LO_A - 8'd1;
					5: ch = CH_LO_A;
					6: ch = CH_LO_Z;
					default: ch = CH_LO_Z + 8'd1;
				endcase
			end
		endcase
		if (pick < 8) begin
			if ($urandom_range(0, 3) == 0)
				data = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff - $urandom_range(0, 30)
					: DATA_W'($urandom_range(0, 30));
			send_word(CMD_WRITE, SEED_OFFSET, SIZE_W'($urandom_range(0, 15)), data, MODEL, '0);
		end else if (pick < 14) begin
			send_word(CMD_READ, SEED_OFFSET, SIZE_W'($urandom_range(0, 15)), data, MODEL, '0);
		end else if (pick < 50) begin
			data[7:0] = ch;
			send_word(CMD_WRITE, BUF_BASE + ADDR_W'(pos), BUF_SIZE, data, MODEL, '0);
		end else if (pick < 85) begin
			send_word(CMD_READ, BUF_BASE + ADDR_W'(pos), BUF_SIZE, data, MODEL, '0);
		end else begin
			send_word(1'($urandom), ADDR_W'($urandom), SIZE_W'($urandom), data, MODEL, '0);
		end
	endtask

	// sender holds off until every outstanding read word has come back
	task automatic wait_reads_done();
		while (pending_reads.size() != 0)
			@(posedge clk);
	endtask

	// response side: random back-pressure plus an occasional long hold-off
	initial begin
		stall_seen = 0;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req != stall_seen) begin
				stall_seen = stall_req;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// response checker: every accepted word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_reads.size() == 0) begin
				$error("read_data: expected none, actual %08h", rsp_ch.read_data);
				fail_cnt++;
			end else if (rsp_ch.read_data !== pending_reads[0]) begin
				$error("read_data: expected %08h, actual %08h", pending_reads[0],
					rsp_ch.read_data);
				fail_cnt++;
				void'(pending_reads.pop_front());
			end else begin
				void'(pending_reads.pop_front());
			end
		end
	end

	// watchdog: too long without any handshake on either channel
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_MAX)
				break;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		fail_cnt      = 0;
		stall_req     = 0;
		send_idle_pct = 17;
		recv_idle_pct = 80;
		model_seed    = '0;
		foreach (model_text[i])
			model_text[i] = 8'h00;

		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.command     <= CMD_READ;
		req_ch.address     <= '0;
		req_ch.access_size <= '0;
		req_ch.write_data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the first idling profile
		for (int i = 0; i < DIR_ROWS; i++)
			send_word(DIRECTED[i].cmd, DIRECTED[i].addr, DIRECTED[i].size,
				DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].exp_rd);

		// light sender gaps, heavy response back-pressure
		for (int i = 0; i < PHASE_WORDS; i++)
			send_random_word();

		// the sender now pauses until the response side has caught up
		req_ch.valid <= 1'b0;
		wait_reads_done();
		send_idle_pct = 80;
		recv_idle_pct = 17;
		for (int i = 0; i < PHASE_WORDS; i++)
			send_random_word();

		req_ch.valid <= 1'b0;
		wait_reads_done();
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// long response hold-off while reads keep coming, so the input backs up
		stall_req++;
		for (int i = 0; i < BURST_WORDS; i++)
			send_word(CMD_READ, BUF_BASE + ADDR_W'($urandom_range(0, 31)), BUF_SIZE,
				$urandom, MODEL, '0);

		// no idling on either side
		for (int i = 0; i < PHASE_WORDS; i++)
			send_random_word();
		req_ch.valid <= 1'b0;

		// drain, then allow a seed write still in its remainder pass to settle
		wait_reads_done();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
